FILE: src/aeg_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// Used by the datapath, controller and top level; no dependencies.
package aeg_pkg;

   localparam int LEVEL_W     = 12;
   localparam int PHASE_W     = 3;
   localparam int CFG_LEN_W   = 12;
   localparam int TABLE_LEN_W = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE   = 3'd4;

   localparam logic [CFG_LEN_W-1:0]   ATTACK_RST  = 12'd512;
   localparam logic [CFG_LEN_W-1:0]   DECAY_RST   = 12'd256;
   localparam logic [CFG_LEN_W-1:0]   SUSTAIN_RST = 12'd2048;
   localparam logic [CFG_LEN_W-1:0]   RELEASE_RST = 12'd512;
   localparam logic [TABLE_LEN_W-1:0] TABLE_RST   = 13'd1024;

   localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;
   localparam logic [PHASE_W-1:0] PH_REST    = 3'd5;

   localparam logic [1:0] DIV_ATT = 2'd0;
   localparam logic [1:0] DIV_DEC = 2'd1;
   localparam logic [1:0] DIV_REL = 2'd2;

   typedef struct packed {
      logic       take;
      logic       div_start;
      logic [1:0] div_sel;
      logic       eval;
      logic       commit;
   } aeg_cmd_type;

   typedef struct packed {
      logic steps_ok;
      logic div_done;
      logic need_rel;
      logic out_free;
   } aeg_stat_type;

endpackage

FILE: src/aeg_divider.sv
// Restoring divider, one quotient bit per cycle.
// Stand-alone; no package needed.
module aeg_divider #(
   parameter int DIVIDEND_W = 12,
   parameter int DIVISOR_W  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(DIVIDEND_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/aeg_datapath.sv
// Datapath: config registers, envelope state, phase evaluation and result register.
// Depends on aeg_pkg and aeg_divider; driven by aeg_controller.
module aeg_datapath
   import aeg_pkg::*;
#(
   parameter int LEVEL_MAX = 4095,
   parameter int MAX_TABLE = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_restart,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [LEVEL_W-1:0]     rsp_level,
   output logic [PHASE_W-1:0]     rsp_phase,
   output logic                   rsp_last,
   input  aeg_cmd_type            cmd,
   output aeg_stat_type           stat
);

   localparam int LW = $clog2(LEVEL_MAX + 1);
   localparam int PW = $clog2(MAX_TABLE);
   localparam int NW = $clog2(MAX_TABLE + 1);
   localparam int CW = ((NW > TABLE_LEN_W) ? NW : TABLE_LEN_W) + 1;
   localparam int OW = (LW > LEVEL_W) ? LW : LEVEL_W;
   localparam int SW = (LW > CFG_LEN_W) ? LW : CFG_LEN_W;
   localparam logic [LW-1:0] TOP       = LW'(LEVEL_MAX);
   localparam logic [CW-1:0] TABLE_TOP = CW'(MAX_TABLE);

   logic [CFG_LEN_W-1:0]   attack_len_ff, decay_len_ff, sustain_ff, release_len_ff;
   logic [TABLE_LEN_W-1:0] table_len_ff;

   logic [PW-1:0]      pos_ff;
   logic [LW-1:0]      lvl_ff, rstep_ff, att_step_ff, dec_step_ff;
   logic [PHASE_W-1:0] ph_ff;
   logic               steps_ok_ff;
   logic [1:0]         div_sel_ff;

   logic [LW-1:0]      wlvl_ff;
   logic [PHASE_W-1:0] wph_ff;
   logic               wset_ff;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;

   logic [CFG_LEN_W-1:0] att, dec, rls;
   logic [SW-1:0]        sus_ext;
   logic [LW-1:0]        sus;
   logic [CW-1:0]        tl, n, rel_at, p_c;
   logic                 is_last;

   logic [LW-1:0]        a_lvl, b_lvl;
   logic [PHASE_W-1:0]   a_ph, b_ph;
   logic                 a_set, a_div;
   logic [OW-1:0]        lvl_ext;

   logic [LW-1:0]        div_dividend;
   logic [CFG_LEN_W-1:0] div_divisor;
   logic                 div_done;
   logic [LW-1:0]        div_quotient;

   assign att     = (attack_len_ff == '0) ? CFG_LEN_W'(1) : attack_len_ff;
   assign dec     = (decay_len_ff == '0) ? CFG_LEN_W'(1) : decay_len_ff;
   assign rls     = (release_len_ff == '0) ? CFG_LEN_W'(1) : release_len_ff;
   assign sus_ext = SW'(sustain_ff);
   assign sus     = (sus_ext > SW'(TOP)) ? TOP : LW'(sus_ext);
   assign tl      = CW'(table_len_ff);
   assign n       = (tl < CW'(2)) ? CW'(2) : ((tl > TABLE_TOP) ? TABLE_TOP : tl);
   assign rel_at  = n >> 1;
   assign p_c     = CW'(pos_ff);
   assign is_last = (p_c == n - CW'(1));

   // start, attack, decay and sustain, falling through within one tick
   always_comb begin
      a_lvl = lvl_ff;
      a_ph  = ph_ff;
      a_set = 1'b0;
      a_div = 1'b0;
      if (pos_ff == '0) begin
         a_lvl = '0;
         a_ph  = PH_START;
         a_set = 1'b1;
      end else if (a_ph == PH_START) begin
         a_ph = PH_ATTACK;
      end
      if (!a_set && a_ph == PH_ATTACK) begin
         if (p_c < CW'(att) && p_c < rel_at &&
             ({1'b0, a_lvl} + {1'b0, att_step_ff}) <= {1'b0, TOP}) begin
            a_lvl = a_lvl + att_step_ff;
            a_set = 1'b1;
         end else begin
            a_ph = PH_DECAY;
         end
      end
      if (!a_set && a_ph == PH_DECAY) begin
         if (p_c < (CW'(att) + CW'(dec)) && p_c < rel_at) begin
            if ({1'b0, a_lvl} < ({1'b0, sus} + {1'b0, dec_step_ff})) begin
               a_lvl = sus;
               a_ph  = PH_SUSTAIN;
            end else begin
               a_lvl = a_lvl - dec_step_ff;
            end
            a_set = 1'b1;
         end else begin
            a_ph = PH_SUSTAIN;
         end
      end
      if (!a_set && a_ph == PH_SUSTAIN) begin
         if (p_c < rel_at) begin
            a_lvl = sus;
            a_set = 1'b1;
         end else begin
            a_div = 1'b1;
            a_ph  = PH_RELEASE;
         end
      end
   end

   // release and rest
   always_comb begin
      b_lvl = wlvl_ff;
      b_ph  = wph_ff;
      if (!wset_ff) begin
         if (wph_ff == PH_RELEASE && p_c < (rel_at + CW'(rls))) begin
            b_lvl = (wlvl_ff >= rstep_ff) ? wlvl_ff - rstep_ff : '0;
         end else begin
            b_ph  = PH_REST;
            b_lvl = '0;
         end
      end
   end

   assign lvl_ext = OW'(b_lvl);

   always_comb begin
      case (cmd.div_sel)
         DIV_DEC: begin
            div_dividend = TOP - sus;
            div_divisor  = dec;
         end
         DIV_REL: begin
            div_dividend = a_lvl;
            div_divisor  = rls;
         end
         default: begin
            div_dividend = TOP;
            div_divisor  = att;
         end
      endcase
   end

   aeg_divider #(
      .DIVIDEND_W (LW),
      .DIVISOR_W  (CFG_LEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= ATTACK_RST;
         decay_len_ff   <= DECAY_RST;
         sustain_ff     <= SUSTAIN_RST;
         release_len_ff <= RELEASE_RST;
         table_len_ff   <= TABLE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ATTACK:  attack_len_ff  <= csr_data[CFG_LEN_W-1:0];
            CSR_DECAY:   decay_len_ff   <= csr_data[CFG_LEN_W-1:0];
            CSR_SUSTAIN: sustain_ff     <= csr_data[CFG_LEN_W-1:0];
            CSR_RELEASE: release_len_ff <= csr_data[CFG_LEN_W-1:0];
            CSR_TABLE:   table_len_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // cached attack and decay steps, stale after a write to their inputs
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ok_ff <= 1'b0;
      end else if (csr_write && (csr_index == CSR_ATTACK || csr_index == CSR_DECAY ||
                                 csr_index == CSR_SUSTAIN)) begin
         steps_ok_ff <= 1'b0;
      end else if (div_done && div_sel_ff == DIV_DEC) begin
         steps_ok_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_done && div_sel_ff == DIV_ATT) begin
         att_step_ff <= div_quotient;
      end
      if (div_done && div_sel_ff == DIV_DEC) begin
         dec_step_ff <= div_quotient;
      end
      if (cmd.eval) begin
         wlvl_ff <= a_lvl;
         wph_ff  <= a_ph;
         wset_ff <= a_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         lvl_ff   <= '0;
         ph_ff    <= PH_START;
         rstep_ff <= '0;
      end else if (cmd.take) begin
         if (req_restart || p_c >= n) begin
            pos_ff   <= '0;
            lvl_ff   <= '0;
            ph_ff    <= PH_START;
            rstep_ff <= '0;
         end
      end else if (div_done && div_sel_ff == DIV_REL) begin
         rstep_ff <= div_quotient;
      end else if (cmd.commit) begin
         if (is_last) begin
            pos_ff   <= '0;
            lvl_ff   <= '0;
            ph_ff    <= PH_START;
            rstep_ff <= '0;
         end else begin
            pos_ff <= pos_ff + PW'(1);
            lvl_ff <= b_lvl;
            ph_ff  <= b_ph;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_level_ff <= lvl_ext[LEVEL_W-1:0];
         rsp_phase_ff <= b_ph;
         rsp_last_ff  <= is_last;
      end
   end

   assign stat.steps_ok = steps_ok_ff;
   assign stat.div_done = div_done;
   assign stat.need_rel = a_div;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_phase = rsp_phase_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: src/aeg_controller.sv
// Sequencer for one envelope tick: step divisions, evaluation, result hand-off.
// Depends on aeg_pkg; commands aeg_datapath.
module aeg_controller
   import aeg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  aeg_stat_type stat,
   output aeg_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DIV_ATT = 3'd1;
   localparam logic [2:0] S_DIV_DEC = 3'd2;
   localparam logic [2:0] S_EVAL    = 3'd3;
   localparam logic [2:0] S_DIV_REL = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (!stat.steps_ok) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_ATT;
                  state_in      = S_DIV_ATT;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_DIV_ATT: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DEC;
               state_in      = S_DIV_DEC;
            end
         end
         S_DIV_DEC: begin
            if (stat.div_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.need_rel) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_REL;
               state_in      = S_DIV_REL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV_REL: begin
            if (stat.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/adsr_envelope_generator.sv
// ADSR envelope generator top level: one envelope sample per request.
// An accepted request passes through the evaluation and finish states, plus the release step
// division at the gate release and, after reset or a write to attack, decay or sustain, the attack
// and decay step divisions first; the result is registered at commit, and idle takes the next.
// The next request is taken while a finished result waits; a result still waiting holds the next.
// Synchronous reset restores the config reset values and clears the envelope state.
module adsr_envelope_generator
   import aeg_pkg::*;
#(
   parameter int LEVEL_MAX = 4095,
   parameter int MAX_TABLE = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_level,
   output logic [PHASE_W-1:0]     rsp_phase,
   output logic                   rsp_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   aeg_cmd_type  cmd;
   aeg_stat_type stat;

   aeg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   aeg_datapath #(
      .LEVEL_MAX (LEVEL_MAX),
      .MAX_TABLE (MAX_TABLE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_restart (req_restart),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_level   (rsp_level),
      .rsp_phase   (rsp_phase),
      .rsp_last    (rsp_last),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
